/* hdl/wgm_pkg.sv */
package wgm_pkg;

    typedef enum logic [1:0] {
        FUNC_APPEND  = 2'd0,
        FUNC_SUBJECT = 2'd1,
        FUNC_END     = 2'd2,
        FUNC_CLEAR   = 2'd3
    } t_func;

    localparam int CODE_ANY_ONE = 63;   // '?'
    localparam int CODE_ANY_RUN = 42;   // '*'
    localparam int FOLD_LOW     = 97;   // 'a'
    localparam int FOLD_HIGH    = 122;  // 'z'
    localparam int FOLD_DIST    = 32;

    function automatic logic [31:0] fold_char(input logic [31:0] c, input logic fold);
        logic [31:0] r;
        r = c;
        if (fold && c >= 32'(FOLD_LOW) && c <= 32'(FOLD_HIGH)) begin
            r = c - 32'(FOLD_DIST);
        end
        return r;
    endfunction

endpackage

/* hdl/wgm_step.sv */
module wgm_step #(
    parameter int PATTERN_MAX = 32,
    parameter int CHAR_BITS   = 16
) (
    input  logic [PATTERN_MAX:0]    i_live,
    input  logic [CHAR_BITS-1:0]    i_store [PATTERN_MAX],
    input  logic [PATTERN_MAX-1:0]  i_used,
    input  logic [CHAR_BITS-1:0]    i_code,
    input  logic                    i_case_fold,
    output logic [PATTERN_MAX:0]    o_closed,
    output logic [PATTERN_MAX:0]    o_next
);
    import wgm_pkg::*;

    logic [PATTERN_MAX:0]   star;
    logic [PATTERN_MAX:0]   gen;
    logic [PATTERN_MAX:0]   sum;
    logic [PATTERN_MAX-1:0] hit;
    logic [PATTERN_MAX-1:0] stay;
    logic [31:0]            sc;

    always_comb begin
        star = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            star[i] = i_used[i] && (i_store[i] == CHAR_BITS'(CODE_ANY_RUN));
        end
    end

    // Star runs propagate like a carry: generate = live star, propagate = star.
    assign gen      = i_live & star;
    assign sum      = star + gen;
    assign o_closed = i_live | (sum ^ star ^ gen);

    assign sc = fold_char(32'(i_code), i_case_fold);

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            stay[i] = o_closed[i] && star[i];
            hit[i]  = i_used[i] && o_closed[i] && !star[i] &&
                      ((i_store[i] == CHAR_BITS'(CODE_ANY_ONE)) ||
                       (fold_char(32'(i_store[i]), i_case_fold) == sc));
        end
    end

    assign o_next = {hit, 1'b0} | {1'b0, stay};

endmodule

/* hdl/wildcard_glob_matcher.sv */
// Anchored glob matcher with '?' and '*'. Load the pattern with append transfers
// (func 0), stream subject characters (func 1), then end the subject (func 2),
// which returns one result with matched and pattern_overflow and rearms the
// matcher; func 3 clears the pattern. Every item passes through the input
// register and then the evaluation stage, which updates the live-position
// vector: a new item is taken every clock, since the vector update (compares
// per position plus a carry-style star closure across the PATTERN_MAX
// positions) is combinational. Only end-of-subject items wait on the result register.
module wildcard_glob_matcher #(
    parameter int PATTERN_MAX = 32,
    parameter int CHAR_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_matched,
    output logic        o_pattern_overflow
);
    import wgm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic                   r_fold;
    logic                   r_in_valid;
    t_func                  r_func;
    logic [CHAR_BITS-1:0]   r_code;
    logic [CHAR_BITS-1:0]   r_store [PATTERN_MAX];
    logic [LEN_W-1:0]       r_len;
    logic [PATTERN_MAX:0]   r_live;
    logic                   r_ovf;
    logic                   r_out_valid;
    logic                   r_matched;
    logic                   r_out_ovf;

    logic [31:0]            code_wide;
    logic [PATTERN_MAX-1:0] used;
    logic [PATTERN_MAX:0]   closed;
    logic [PATTERN_MAX:0]   next_live;
    logic                   advance;

    assign code_wide = {16'b0, i_char_code};

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            used[i] = LEN_W'(i) < r_len;
        end
    end

    wgm_step #(
        .PATTERN_MAX (PATTERN_MAX),
        .CHAR_BITS   (CHAR_BITS)
    ) u_step (
        .i_live      (r_live),
        .i_store     (r_store),
        .i_used      (used),
        .i_code      (r_code),
        .i_case_fold (r_fold),
        .o_closed    (closed),
        .o_next      (next_live)
    );

    assign advance    = r_in_valid && (r_func != FUNC_END || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid        = r_out_valid;
    assign o_matched          = r_matched;
    assign o_pattern_overflow = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= 1'b0;
        end else if (i_cfg_we) begin
            r_fold <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func <= t_func'(i_func);
            r_code <= code_wide[CHAR_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_func == FUNC_APPEND && r_len < LEN_W'(PATTERN_MAX)) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                if (r_len == LEN_W'(i)) begin
                    r_store[i] <= r_code;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_live <= (PATTERN_MAX + 1)'(1);
            r_ovf  <= 1'b0;
        end else if (advance) begin
            case (r_func)
                FUNC_APPEND: begin
                    if (r_len < LEN_W'(PATTERN_MAX)) begin
                        r_len <= r_len + LEN_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                FUNC_SUBJECT: begin
                    r_live <= next_live;
                end
                FUNC_END: begin
                    r_live <= (PATTERN_MAX + 1)'(1);
                end
                FUNC_CLEAR: begin
                    r_len  <= '0;
                    r_ovf  <= 1'b0;
                    r_live <= (PATTERN_MAX + 1)'(1);
                end
                default: begin
                    r_live <= r_live;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_func == FUNC_END) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_func == FUNC_END) begin
            r_matched <= closed[r_len];
            r_out_ovf <= r_ovf;
        end
    end

endmodule
